// ----- design/baro_temp_pressure_compensation_core_defines.svh -----
// Assertion macros shared by the compensation core.
// Standalone header: no dependencies.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_CORE_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_CORE_DEFINES_SVH

// same-cycle implication
`define BTPC_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("btpc check failed");

// next-cycle implication
`define BTPC_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("btpc check failed");

`endif

// ----- design/btpc_pkg.sv -----
// Types, constants and arithmetic helpers for the compensation core.
// No dependencies.
`default_nettype none

package btpc_pkg;

  localparam int DIV_STEPS  = 64;
  localparam int PRE_STAGES = 11;
  localparam int POST_STAGES = 4;
  localparam int PIPE_DEPTH = PRE_STAGES + DIV_STEPS + POST_STAGES;

  localparam logic signed [33:0] T_FINE_OFFSET = 34'sd128000;
  localparam logic [20:0]        P_RAW_FULL    = 21'd1048576;
  localparam logic signed [16:0] P_SCALE       = 17'sd3125;
  localparam logic [63:0]        W_BIAS        = 64'h0000_8000_0000_0000;
  localparam logic [63:0]        ROUND_NEG     = 64'd255;
  localparam logic [31:0]        T_ROUND       = 32'd128;

  typedef enum logic [1:0] {
    REG_TEMP_CALIB  = 2'd0,
    REG_PRESS_A     = 2'd1,
    REG_PRESS_B     = 2'd2,
    REG_PRESS_C     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic               divide_fault;
  } out_word_t;

  typedef struct packed {
    logic [63:0]        rem;
    logic [63:0]        nq;
    logic [63:0]        md;
    logic               neg;
    logic               fault;
    logic signed [31:0] temperature;
  } div_word_t;

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned sh);
    return $signed(x) >>> sh;
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned sh);
    return $signed(x) >>> sh;
  endfunction

  function automatic logic [63:0] sx64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // low 64 bits of x * s, as two 33x17 partial products
  function automatic logic [63:0] mul64x16s(input logic [63:0] x,
                                            input logic signed [16:0] s);
    logic signed [49:0] pl;
    logic signed [49:0] ph;
    pl = $signed({1'b0, x[31:0]}) * s;
    ph = $signed({1'b0, x[63:32]}) * s;
    return {{14{pl[49]}}, pl} + {ph[31:0], 32'd0};
  endfunction

endpackage

`default_nettype wire

// ----- design/btpc_div_stage.sv -----
// One restoring step of the unsigned 64-bit divider chain.
// Depends on btpc_pkg.
`default_nettype none

module btpc_div_stage import btpc_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  div_word_t din,
  output div_word_t dout
);

  div_word_t   dout_next;
  logic [63:0] trial;
  logic        ge;

  // with a nonzero divisor the remainder stays below it, so its top bit is clear
  always_comb begin
    trial          = {din.rem[62:0], din.nq[63]};
    ge             = (trial >= din.md);
    dout_next      = din;
    dout_next.rem  = ge ? (trial - din.md) : trial;
    dout_next.nq   = {din.nq[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/baro_temp_pressure_compensation_core.sv -----
// Barometric temperature/pressure compensation core: one raw word in, one
// compensated word out. Accepts a word every cycle unless the output is stalled;
// the path is the 64-step pipelined divider plus 11 stages before it and 5 after.
// Calibration writes are always accepted (cfg_ready is tied high).
// Depends on btpc_pkg, btpc_div_stage and the defines header.
`default_nettype none
`include "baro_temp_pressure_compensation_core_defines.svh"

module baro_temp_pressure_compensation_core import btpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [47:0] temp_calib;
  logic [47:0] press_calib_a;
  logic [63:0] press_calib_b;
  logic [31:0] press_calib_c;

  logic adv;
  logic [PIPE_DEPTH-1:0] vld;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      press_calib_c <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TEMP_CALIB: temp_calib    <= cfg_data[47:0];
        REG_PRESS_A:    press_calib_a <= cfg_data[47:0];
        REG_PRESS_B:    press_calib_b <= cfg_data;
        REG_PRESS_C:    press_calib_c <= cfg_data[31:0];
      endcase
    end
  end

  logic [15:0]        t1, p1, p3, p4, p6, p7, p8, p9;
  logic signed [15:0] t2, t3, p2, p5;

  assign t1 = temp_calib[15:0];
  assign t2 = $signed(temp_calib[31:16]);
  assign t3 = $signed(temp_calib[47:32]);
  assign p1 = press_calib_a[15:0];
  assign p2 = $signed(press_calib_a[31:16]);
  assign p3 = press_calib_a[47:32];
  assign p4 = press_calib_b[15:0];
  assign p5 = $signed(press_calib_b[31:16]);
  assign p6 = press_calib_b[47:32];
  assign p7 = press_calib_b[63:48];
  assign p8 = press_calib_c[15:0];
  assign p9 = press_calib_c[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[PIPE_DEPTH-2:0], in_valid};
      out_valid <= vld[PIPE_DEPTH-1];
    end
  end

  // temperature front end and pressure numerator/denominator ahead of the divider
  logic signed [17:0] x1_s1;
  logic signed [16:0] d_s1;
  logic [19:0]        adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7, adcp_s8;
  logic signed [33:0] ma_s2;
  logic [31:0]        dd_s2;
  logic [31:0]        a_s3, bb_s3;
  logic [31:0]        fine_s4;
  logic [31:0]        temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10;
  logic signed [33:0] v1_s5;
  logic [31:0]        vabs_s5;
  logic [63:0]        sq_s6;
  logic signed [49:0] v1p5_s6, v1p2_s6;
  logic [63:0]        sqp6_s7, sqp3_s7;
  logic signed [49:0] v1p5_s7, v1p2_s7;
  logic [63:0]        v2_s8, w_s8;
  logic [63:0]        wp1_s9, nbase_s9;
  logic [63:0]        den_s10, num_s10;
  div_word_t          div_in;

  logic signed [17:0] x1_next;
  logic signed [16:0] d_next;
  logic signed [33:0] ma_next;
  logic signed [33:0] dsq;
  logic signed [31:0] bsh;
  logic signed [47:0] bprod;
  logic [31:0]        fine_next, f5;
  logic signed [33:0] v1_next, v1_neg;
  logic [31:0]        vabs_next;
  logic [63:0]        v2_next, w_next, nbase_next;
  logic [20:0]        praw;
  div_word_t          div_next;

  always_comb begin
    x1_next   = $signed({1'b0, in_word.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    d_next    = $signed({1'b0, in_word.raw_temperature[19:4]}) - $signed({1'b0, t1});
    ma_next   = x1_s1 * t2;
    dsq       = d_s1 * d_s1;
    bsh       = asr32(dd_s2, 12);
    bprod     = bsh * t3;
    fine_next = a_s3 + asr32(bb_s3, 14);
    f5        = fine_s4 + {fine_s4[29:0], 2'b00} + T_ROUND;
    v1_next   = $signed({{2{fine_s4[31]}}, fine_s4}) - T_FINE_OFFSET;
    v1_neg    = -v1_next;
    vabs_next = v1_next[33] ? v1_neg[31:0] : v1_next[31:0];
    v2_next   = sqp6_s7 + ({{14{v1p5_s7[49]}}, v1p5_s7} << 17) + (sx64(p4) << 35);
    w_next    = W_BIAS + asr64(sqp3_s7, 8) + ({{14{v1p2_s7[49]}}, v1p2_s7} << 12);
    praw      = P_RAW_FULL - {1'b0, adcp_s8};
    nbase_next = ({43'd0, praw} << 31) - v2_s8;
    div_next.rem         = '0;
    div_next.nq          = num_s10[63] ? (64'd0 - num_s10) : num_s10;
    div_next.md          = den_s10[63] ? (64'd0 - den_s10) : den_s10;
    div_next.neg         = num_s10[63] ^ den_s10[63];
    div_next.fault       = (den_s10 == 64'd0);
    div_next.temperature = $signed(temp_s10);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_s1    <= x1_next;
      d_s1     <= d_next;
      adcp_s1  <= in_word.raw_pressure;
      ma_s2    <= ma_next;
      dd_s2    <= dsq[31:0];
      adcp_s2  <= adcp_s1;
      a_s3     <= asr32(ma_s2[31:0], 11);
      bb_s3    <= bprod[31:0];
      adcp_s3  <= adcp_s2;
      fine_s4  <= fine_next;
      adcp_s4  <= adcp_s3;
      temp_s5  <= asr32(f5, 8);
      v1_s5    <= v1_next;
      vabs_s5  <= vabs_next;
      adcp_s5  <= adcp_s4;
      sq_s6    <= vabs_s5 * vabs_s5;
      v1p5_s6  <= v1_s5 * p5;
      v1p2_s6  <= v1_s5 * p2;
      temp_s6  <= temp_s5;
      adcp_s6  <= adcp_s5;
      sqp6_s7  <= mul64x16s(sq_s6, {p6[15], p6});
      sqp3_s7  <= mul64x16s(sq_s6, {p3[15], p3});
      v1p5_s7  <= v1p5_s6;
      v1p2_s7  <= v1p2_s6;
      temp_s7  <= temp_s6;
      adcp_s7  <= adcp_s6;
      v2_s8    <= v2_next;
      w_s8     <= w_next;
      temp_s8  <= temp_s7;
      adcp_s8  <= adcp_s7;
      wp1_s9   <= mul64x16s(w_s8, {1'b0, p1});
      nbase_s9 <= nbase_next;
      temp_s9  <= temp_s8;
      den_s10  <= asr64(wp1_s9, 33);
      num_s10  <= mul64x16s(nbase_s9, P_SCALE);
      temp_s10 <= temp_s9;
      div_in   <= div_next;
    end
  end

  // magnitude divider, one quotient bit per stage
  div_word_t div_w [DIV_STEPS+1];

  assign div_w[0] = div_in;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    btpc_div_stage u_stage (
      .clk  (clk),
      .en   (adv),
      .din  (div_w[k]),
      .dout (div_w[k+1])
    );
  end

  // pressure back end
  div_word_t   div_out;
  logic [63:0] pq_p1, pq_p2, pq_p3;
  logic [31:0] temp_p1, temp_p2, temp_p3, temp_p4;
  logic        fault_p1, fault_p2, fault_p3, fault_p4;
  logic [63:0] hh_p2, p8pq_p2, p8pq_p3, w1m_p3, s_p4;

  logic [63:0] h, llp, lhp, sum_next, s_next, rnd;
  out_word_t   out_next;

  assign div_out = div_w[DIV_STEPS];

  always_comb begin
    h        = asr64(pq_p1, 13);
    llp      = h[31:0] * h[31:0];
    lhp      = h[31:0] * h[63:32];
    sum_next = pq_p3 + asr64(w1m_p3, 25) + asr64(p8pq_p3, 19);
    s_next   = asr64(sum_next, 8) + (sx64(p7) << 4);
    rnd      = asr64(s_p4 + (s_p4[63] ? ROUND_NEG : 64'd0), 8);
    out_next.temperature  = $signed(temp_p4);
    out_next.pressure     = fault_p4 ? 32'd0 : rnd[31:0];
    out_next.divide_fault = fault_p4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pq_p1    <= div_out.neg ? (64'd0 - div_out.nq) : div_out.nq;
      temp_p1  <= div_out.temperature;
      fault_p1 <= div_out.fault;
      hh_p2    <= llp + {lhp[30:0], 33'd0};
      p8pq_p2  <= mul64x16s(pq_p1, {p8[15], p8});
      pq_p2    <= pq_p1;
      temp_p2  <= temp_p1;
      fault_p2 <= fault_p1;
      w1m_p3   <= mul64x16s(hh_p2, {p9[15], p9});
      p8pq_p3  <= p8pq_p2;
      pq_p3    <= pq_p2;
      temp_p3  <= temp_p2;
      fault_p3 <= fault_p2;
      s_p4     <= s_next;
      temp_p4  <= temp_p3;
      fault_p4 <= fault_p3;
      out_word <= out_next;
    end
  end

  `BTPC_ASSERT_IMP(a_fault_zero, clk, rst, out_valid && out_word.divide_fault, out_word.pressure == 32'd0)
  `BTPC_ASSERT_NXT(a_stall_holds, clk, rst, !adv, $stable(vld))
  `BTPC_ASSERT_NXT(a_accept_enters, clk, rst, in_valid && in_ready, vld[0])

endmodule

`default_nettype wire

// ----- bench/tb_baro_temp_pressure_compensation_core.sv -----
// Self-checking bench for baro_temp_pressure_compensation_core: a directed table,
// then random words, checked against an in-bench compensation predictor.
// Depends on btpc_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_baro_temp_pressure_compensation_core;
  import btpc_pkg::*;

  typedef struct {
    in_word_t  raw;
    bit        typed;
    out_word_t result;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_TEMP_CALIB;
  logic [63:0] cfg_data = '0;

  logic [47:0] cal_t = '0;
  logic [47:0] cal_a = '0;
  logic [63:0] cal_b = '0;
  logic [31:0] cal_c = '0;

  out_word_t pending_results[$];
  int        errors = 0;
  int        burst_left = 0;
  int        hold_req = 0;
  int        hold_left = 0;
  int        ready_cnt = 0;
  table_row_t rows[$];

  baro_temp_pressure_compensation_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [63:0] ext16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] x, input int s);
    return $signed(x) >>> s;
  endfunction

  function automatic logic [63:0] quot64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    return (n[63] ^ d[63]) ? -q : q;
  endfunction

  function automatic out_word_t compensate(input in_word_t w);
    logic [31:0] adct, t1, t2, t3, x, a, dd, b, fine;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, pr, h, w1, w2, pq;
    out_word_t r;
    adct = {12'd0, w.raw_temperature};
    t1 = {16'd0, cal_t[15:0]};
    t2 = {{16{cal_t[31]}}, cal_t[31:16]};
    t3 = {{16{cal_t[47]}}, cal_t[47:32]};
    x = (adct >> 3) - (t1 << 1);
    x = x * t2;
    a = $signed(x) >>> 11;
    dd = (adct >> 4) - t1;
    x = dd * dd;
    x = $signed(x) >>> 12;
    x = x * t3;
    b = $signed(x) >>> 14;
    fine = a + b;
    x = fine * 32'd5 + 32'd128;
    r.temperature = $signed(x) >>> 8;
    p1 = {48'd0, cal_a[15:0]};
    p2 = ext16(cal_a[31:16]);
    p3 = ext16(cal_a[47:32]);
    p4 = ext16(cal_b[15:0]);
    p5 = ext16(cal_b[31:16]);
    p6 = ext16(cal_b[47:32]);
    p7 = ext16(cal_b[63:48]);
    p8 = ext16(cal_c[15:0]);
    p9 = ext16(cal_c[31:16]);
    v1 = {{32{fine[31]}}, fine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
    r.pressure = '0;
    r.divide_fault = 1'b0;
    if (v1 == 64'd0) begin
      r.divide_fault = 1'b1;
    end else begin
      pr = 64'd1048576 - {44'd0, w.raw_pressure};
      pr = quot64(((pr << 31) - v2) * 64'd3125, v1);
      h = sra64(pr, 13);
      w1 = sra64(p9 * h * h, 25);
      w2 = sra64(p8 * pr, 19);
      pr = sra64(pr + w1 + w2, 8) + (p7 << 4);
      pq = quot64(pr, 64'd256);
      r.pressure = pq[31:0];
    end
    return r;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TEMP_CALIB: cal_t = data[47:0];
      REG_PRESS_A:    cal_a = data[47:0];
      REG_PRESS_B:    cal_b = data;
      REG_PRESS_C:    cal_c = data[31:0];
    endcase
  endtask

  task automatic load_calib(input logic [47:0] t, input logic [47:0] a,
                            input logic [63:0] b, input logic [31:0] c);
    write_reg(REG_TEMP_CALIB, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | t);
    write_reg(REG_PRESS_A, {16'hFFFF, a});
    write_reg(REG_PRESS_B, b);
    write_reg(REG_PRESS_C, {$urandom, c});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t res);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(typed ? res : compensate(w));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [19:0] rand_raw();
    case ($urandom_range(0, 5))
      0: return 20'd0;
      1: return 20'hFFFFF;
      2: return 20'($urandom_range(400000, 600000));
      default: return 20'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    ready_cnt <= ready_cnt + 1;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (ready_cnt[9:8])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready <= (ready_cnt[2:0] != 3'd0);
        default: out_ready <= $urandom_range(0, 1);
      endcase
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, out_word);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.temperature !== want.temperature) begin
          $display("%0t: temperature expected %0d actual %0d", $time,
                   want.temperature, out_word.temperature);
          errors++;
        end
        if (out_word.pressure !== want.pressure) begin
          $display("%0t: pressure expected %0d actual %0d", $time,
                   want.pressure, out_word.pressure);
          errors++;
        end
        if (out_word.divide_fault !== want.divide_fault) begin
          $display("%0t: divide_fault expected %b actual %b", $time,
                   want.divide_fault, out_word.divide_fault);
          errors++;
        end
      end
    end
  end

  initial begin
    table_row_t row;
    out_word_t zero_fault;
    in_word_t w;
    zero_fault = '{temperature: 0, pressure: 0, divide_fault: 1'b1};
    // all-zero calibration: fine temperature 0, divisor 0
    rows.push_back('{'{20'd0, 20'd0}, 1'b1, zero_fault});
    rows.push_back('{'{20'hFFFFF, 20'hFFFFF}, 1'b1, zero_fault});
    rows.push_back('{'{20'hFFFFF, 20'd0}, 1'b1, zero_fault});
    rows.push_back('{'{20'd0, 20'hFFFFF}, 1'b1, zero_fault});
    rows.push_back('{'{20'h5A5A5, 20'hA5A5A}, 1'b1, zero_fault});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_word(rows[i].raw, rows[i].typed, rows[i].result);
    drain();

    // typical sensor trim
    load_calib({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
               {16'd15500, 16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8});
    rows.delete();
    rows.push_back('{'{20'd519888, 20'd415148}, 1'b0, '0});
    rows.push_back('{'{20'd0, 20'd0}, 1'b0, '0});
    rows.push_back('{'{20'hFFFFF, 20'hFFFFF}, 1'b0, '0});
    rows.push_back('{'{20'hFFFFF, 20'd0}, 1'b0, '0});
    rows.push_back('{'{20'd0, 20'hFFFFF}, 1'b0, '0});
    rows.push_back('{'{20'd500000, 20'd300000}, 1'b0, '0});
    rows.push_back('{'{20'd540000, 20'd1048575}, 1'b0, '0});
    foreach (rows[i]) send_word(rows[i].raw, rows[i].typed, rows[i].result);
    drain();

    // P1 zero with the rest set: divisor zero, temperature still live
    load_calib({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd0},
               {16'd15500, 16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8});
    send_word('{20'd519888, 20'd415148}, 1'b0, '0);
    send_word('{20'hFFFFF, 20'd0}, 1'b0, '0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: load_calib({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
                      {16'd15500, 16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8});
        1: load_calib(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                      32'hFFFF_FFFF);
        2: load_calib(48'h8000_8000_FFFF, 48'h8000_8000_FFFF, 64'h8000_8000_8000_8000,
                      32'h8000_8000);
        3: load_calib(48'h7FFF_7FFF_0001, 48'h7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_7FFF,
                      32'h7FFF_7FFF);
        default: load_calib(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                            {$urandom, $urandom}, $urandom);
      endcase
      if (ph == 4) hold_req = 400;
      for (int n = 0; n < 195; n++) begin
        w.raw_temperature = rand_raw();
        w.raw_pressure = rand_raw();
        send_word(w, 1'b0, '0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/btpc_pkg.sv
design/btpc_div_stage.sv
design/baro_temp_pressure_compensation_core.sv
bench/tb_baro_temp_pressure_compensation_core.sv
